// File: rtl/nsc_pkg.sv
// Shared types, character codes and the sentence kind table of the NMEA sentence checker.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] ARMOR_BASE = 8'd48;
  localparam logic [7:0] ARMOR_GAP  = 8'd40;
  localparam logic [7:0] ARMOR_SKIP = 8'd8;

  localparam int KIND_COUNT = 11;
  localparam logic [3:0] KIND_NONE = 4'd0;
  localparam logic [3:0] KIND_VDM  = 4'd11;

  localparam logic [23:0] KIND_TAGS [KIND_COUNT] = '{
    "GGA", "RMC", "VTG", "HDT", "HDG", "MTW", "DBT", "DPT", "MWV", "MWD", "VDM"
  };
  localparam logic [4:0] KIND_MIN [KIND_COUNT] = '{
    5'd7, 5'd9, 5'd6, 5'd2, 5'd2, 5'd2, 5'd4, 5'd2, 5'd6, 5'd6, 5'd6
  };

  // One classified line byte as it travels from front to back.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       is_start;
    logic       is_comma;
    logic       is_star;
    logic       is_nul;
    logic       is_one;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic [5:0] six;
  } beat_t;

  typedef struct packed {
    logic        checksum_present;
    logic        checksum_valid;
    logic        has_address;
    logic [7:0]  talker_first;
    logic [7:0]  talker_second;
    logic [7:0]  id_first;
    logic [7:0]  id_second;
    logic [7:0]  id_third;
    logic [4:0]  field_count;
    logic [3:0]  sentence_kind;
    logic        mmsi_found;
    logic [29:0] mmsi;
  } result_t;

  // Sentence kind for a three-letter identifier, gated by the kind's minimum field count.
  function automatic logic [3:0] kind_lookup(logic [23:0] tag, logic [4:0] fields);
    logic [3:0] k;
    k = KIND_NONE;
    for (int i = 0; i < KIND_COUNT; i++) begin
      if (KIND_TAGS[i] == tag && fields >= KIND_MIN[i]) begin
        k = 4'(i + 1);
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/nsc_front.sv
// Front end of the NMEA sentence checker: classifies each accepted line byte.
// Depends on nsc_pkg for the beat type and character codes.
`default_nettype none

module nsc_front
  import nsc_pkg::*;
(
  input  wire logic [7:0] byte_in,
  input  wire logic       end_of_line,
  output beat_t           beat
);

  logic [7:0] armor;

  always_comb begin
    beat          = '0;
    beat.ch       = byte_in;
    beat.last     = end_of_line;
    beat.is_start = (byte_in == CH_DOLLAR) || (byte_in == CH_BANG);
    beat.is_comma = (byte_in == CH_COMMA);
    beat.is_star  = (byte_in == CH_STAR);
    beat.is_nul   = (byte_in == 8'd0);
    beat.is_one   = (byte_in == CH_ONE);
    if (byte_in >= CH_ZERO && byte_in <= CH_NINE) begin
      beat.hex_ok  = 1'b1;
      beat.hex_val = 4'(byte_in - CH_ZERO);
    end else if (byte_in >= CH_UA && byte_in <= CH_UF) begin
      beat.hex_ok  = 1'b1;
      beat.hex_val = 4'(byte_in - CH_UA + 8'd10);
    end else if (byte_in >= CH_LA && byte_in <= CH_LF) begin
      beat.hex_ok  = 1'b1;
      beat.hex_val = 4'(byte_in - CH_LA + 8'd10);
    end
    // Six-bit armoring: subtract the base, and close the gap above the letters.
    armor = byte_in - ARMOR_BASE;
    if (armor > ARMOR_GAP) begin
      armor = armor - ARMOR_SKIP;
    end
    beat.six = armor[5:0];
  end

endmodule

`default_nettype wire

// File: rtl/nsc_fifo.sv
// Two-entry queue of classified beats between front and back of the sentence checker.
// Depends on nsc_pkg for the beat type.
`default_nettype none

module nsc_fifo
  import nsc_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire beat_t push_beat,
  output logic       full,
  input  wire logic  pop,
  output logic       not_empty,
  output beat_t      head
);

  beat_t      mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_nxt;
  logic [1:0] count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_beat;
    end
  end

endmodule

`default_nettype wire

// File: rtl/nsc_back.sv
// Back end of the sentence checker: line state, checksum check and the result register.
// Depends on nsc_pkg for the beat and result types and the kind table.
`default_nettype none

module nsc_back
  import nsc_pkg::*;
#(
  parameter int FIELD_CAP = 20
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  beat_avail,
  input  wire beat_t beat,
  output logic       beat_pop,
  output logic       res_valid,
  input  wire logic  res_ready,
  output result_t    res
);

  typedef enum logic [1:0] {PH_START, PH_BODY, PH_STAR, PH_IDLE} phase_t;

  phase_t      phase_r, phase_nxt, phase_upd;
  logic [7:0]  xor_r, xor_nxt;
  logic [2:0]  addr_len_r, addr_len_nxt;
  logic [15:0] talker_r, talker_nxt;
  logic [23:0] id_win_r, id_win_nxt;
  logic [4:0]  field_idx_r, field_idx_nxt;
  logic [2:0]  fchars_r, fchars_nxt;
  logic        frag_one_r, frag_one_nxt;
  logic        pay_long_r, pay_long_nxt;
  logic [29:0] mmsi_r, mmsi_nxt;
  logic [1:0]  star_cnt_r, star_cnt_nxt;
  logic [4:0]  hex_hi_r, hex_hi_nxt;
  logic        res_valid_r, res_valid_nxt;
  result_t     res_r, res_nxt;

  logic        present, valid, addr, found;
  logic [3:0]  kind;

  // A beat that closes a line needs room in the result register; others never wait.
  assign beat_pop  = beat_avail && (!beat.last || !res_valid_r || res_ready);
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    phase_upd     = phase_r;
    xor_nxt       = xor_r;
    addr_len_nxt  = addr_len_r;
    talker_nxt    = talker_r;
    id_win_nxt    = id_win_r;
    field_idx_nxt = field_idx_r;
    fchars_nxt    = fchars_r;
    frag_one_nxt  = frag_one_r;
    pay_long_nxt  = pay_long_r;
    mmsi_nxt      = mmsi_r;
    star_cnt_nxt  = star_cnt_r;
    hex_hi_nxt    = hex_hi_r;

    case (phase_r)
      PH_START: begin
        xor_nxt      = '0;
        addr_len_nxt = '0;
        talker_nxt   = '0;
        id_win_nxt   = '0;
        fchars_nxt   = '0;
        frag_one_nxt = 1'b0;
        pay_long_nxt = 1'b0;
        mmsi_nxt     = '0;
        star_cnt_nxt = '0;
        hex_hi_nxt   = '0;
        if (beat.is_start) begin
          field_idx_nxt = 5'd1;
          phase_upd     = PH_BODY;
        end else begin
          field_idx_nxt = 5'd0;
          phase_upd     = PH_IDLE;
        end
      end
      PH_BODY: begin
        if (beat.is_nul) begin
          phase_upd = PH_IDLE;
        end else if (beat.is_star) begin
          phase_upd = PH_STAR;
        end else begin
          xor_nxt = xor_r ^ beat.ch;
          if (beat.is_comma && field_idx_r < 5'(FIELD_CAP)) begin
            field_idx_nxt = field_idx_r + 5'd1;
            fchars_nxt    = '0;
          end else begin
            if (field_idx_r == 5'd1) begin
              if (addr_len_r == 3'd0) begin
                talker_nxt[15:8] = beat.ch;
              end else if (addr_len_r == 3'd1) begin
                talker_nxt[7:0] = beat.ch;
              end
              if (addr_len_r < 3'd5) begin
                addr_len_nxt = addr_len_r + 3'd1;
              end
              id_win_nxt = {id_win_r[15:0], beat.ch};
            end else if (field_idx_r == 5'd3) begin
              if (fchars_r == 3'd0) begin
                frag_one_nxt = beat.is_one;
              end
            end else if (field_idx_r == 5'd6) begin
              if (fchars_r == 3'd1) begin
                mmsi_nxt = {26'd0, beat.six[3:0]};
              end else if (fchars_r >= 3'd2 && fchars_r <= 3'd5) begin
                mmsi_nxt = {mmsi_r[23:0], beat.six};
              end else if (fchars_r == 3'd6) begin
                mmsi_nxt     = {mmsi_r[27:0], beat.six[5:4]};
                pay_long_nxt = 1'b1;
              end
            end
            if (fchars_r < 3'd7) begin
              fchars_nxt = fchars_r + 3'd1;
            end
          end
        end
      end
      PH_STAR: begin
        if (star_cnt_r == 2'd0) begin
          hex_hi_nxt   = beat.hex_ok ? {1'b1, beat.hex_val} : 5'd0;
          star_cnt_nxt = 2'd1;
        end else if (star_cnt_r == 2'd1) begin
          hex_hi_nxt = {hex_hi_r[4] && beat.hex_ok &&
                        ({hex_hi_r[3:0], beat.hex_val} == xor_r), 4'd0};
          star_cnt_nxt = 2'd2;
        end
      end
      default: begin
      end
    endcase

    phase_nxt = beat.last ? PH_START : phase_upd;

    // Result as the line stands once this beat is taken in.
    present = (phase_upd == PH_STAR);
    valid   = present && (star_cnt_nxt == 2'd2) && hex_hi_nxt[4];
    addr    = (addr_len_nxt >= 3'd5);
    kind    = (valid && addr) ? kind_lookup(id_win_nxt, field_idx_nxt) : KIND_NONE;
    found   = (kind == KIND_VDM) && frag_one_nxt && pay_long_nxt;

    res_nxt = '0;
    if (field_idx_nxt != 5'd0) begin
      res_nxt.checksum_present = present;
      res_nxt.checksum_valid   = valid;
      res_nxt.has_address      = addr;
      if (addr) begin
        res_nxt.talker_first  = talker_nxt[15:8];
        res_nxt.talker_second = talker_nxt[7:0];
        res_nxt.id_first      = id_win_nxt[23:16];
        res_nxt.id_second     = id_win_nxt[15:8];
        res_nxt.id_third      = id_win_nxt[7:0];
      end
      res_nxt.field_count   = field_idx_nxt;
      res_nxt.sentence_kind = kind;
      res_nxt.mmsi_found    = found;
      res_nxt.mmsi          = found ? mmsi_nxt : 30'd0;
    end

    res_valid_nxt = res_valid_r && !res_ready;
    if (beat_pop && beat.last) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      xor_r       <= '0;
      addr_len_r  <= '0;
      talker_r    <= '0;
      id_win_r    <= '0;
      field_idx_r <= '0;
      fchars_r    <= '0;
      frag_one_r  <= 1'b0;
      pay_long_r  <= 1'b0;
      mmsi_r      <= '0;
      star_cnt_r  <= '0;
      hex_hi_r    <= '0;
      res_valid_r <= 1'b0;
      res_r       <= '0;
    end else begin
      res_valid_r <= res_valid_nxt;
      if (beat_pop) begin
        phase_r     <= phase_nxt;
        xor_r       <= xor_nxt;
        addr_len_r  <= addr_len_nxt;
        talker_r    <= talker_nxt;
        id_win_r    <= id_win_nxt;
        field_idx_r <= field_idx_nxt;
        fchars_r    <= fchars_nxt;
        frag_one_r  <= frag_one_nxt;
        pay_long_r  <= pay_long_nxt;
        mmsi_r      <= mmsi_nxt;
        star_cnt_r  <= star_cnt_nxt;
        hex_hi_r    <= hex_hi_nxt;
      end
      if (beat_pop && beat.last) begin
        res_r <= res_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/nmea_sentence_checker.sv
// NMEA 0183 sentence checker, one line byte per beat, one result beat per line.
// out_valid is registered: it rises in the cycle after the back end pops the line-ending beat from the queue.
// Throughput: one byte beat per cycle, except while a line-ending beat is held back in the queue.
// A line-ending beat waits in the queue only while an earlier result is still held.
// Reset (rst_n low, synchronous) empties the queue, drops any held result and awaits a line start.
// Depends on nsc_pkg, nsc_front, nsc_fifo and nsc_back.
`default_nettype none

module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int FIELD_CAP = 20
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte_in,
  input  wire logic        in_end_of_line,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_checksum_present,
  output logic             out_checksum_valid,
  output logic             out_has_address,
  output logic [7:0]       out_talker_first,
  output logic [7:0]       out_talker_second,
  output logic [7:0]       out_id_first,
  output logic [7:0]       out_id_second,
  output logic [7:0]       out_id_third,
  output logic [4:0]       out_field_count,
  output logic [3:0]       out_sentence_kind,
  output logic             out_mmsi_found,
  output logic [29:0]      out_mmsi
);

  // The front classifies each byte (start, comma, star, hex digit, six-bit value)
  // without holding any state of its own; the classified beat goes into a
  // two-entry queue. The back drains that queue, one beat a cycle unless a
  // line-ending beat waits for the result register, and keeps all per-line
  // state. The queue lets the input keep flowing while a result waits downstream.
  beat_t   front_beat;
  beat_t   head_beat;
  logic    q_full;
  logic    q_avail;
  logic    q_pop;
  logic    in_take;
  result_t res;

  assign in_ready = !q_full;
  assign in_take  = in_valid && !q_full;

  nsc_front u_front (
    .byte_in     (in_byte_in),
    .end_of_line (in_end_of_line),
    .beat        (front_beat)
  );

  nsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_take),
    .push_beat (front_beat),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_avail),
    .head      (head_beat)
  );

  nsc_back #(
    .FIELD_CAP (FIELD_CAP)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_avail (q_avail),
    .beat       (head_beat),
    .beat_pop   (q_pop),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  // The result beat is split out onto one port per field.
  assign out_checksum_present = res.checksum_present;
  assign out_checksum_valid   = res.checksum_valid;
  assign out_has_address      = res.has_address;
  assign out_talker_first     = res.talker_first;
  assign out_talker_second    = res.talker_second;
  assign out_id_first         = res.id_first;
  assign out_id_second        = res.id_second;
  assign out_id_third         = res.id_third;
  assign out_field_count      = res.field_count;
  assign out_sentence_kind    = res.sentence_kind;
  assign out_mmsi_found       = res.mmsi_found;
  assign out_mmsi             = res.mmsi;

endmodule

`default_nettype wire

// File: rtl/nsc_checker.sv
// Port-level assertions for the NMEA sentence checker, bound to its top level.
// Depends on the top level's ports and on nsc_pkg for the sentence kind codes.
`default_nettype none

module nsc_checker
  import nsc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_checksum_present,
  input wire logic        out_checksum_valid,
  input wire logic        out_has_address,
  input wire logic [7:0]  out_talker_first,
  input wire logic [7:0]  out_id_third,
  input wire logic [4:0]  out_field_count,
  input wire logic [3:0]  out_sentence_kind,
  input wire logic        out_mmsi_found,
  input wire logic [29:0] out_mmsi
);

  // A held result beat stays until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A kind is reported only for a checked sentence with an address.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_sentence_kind != KIND_NONE |-> out_checksum_valid && out_has_address)
    else $error("sentence kind without valid checksum and address");

  // The identity is shown only when it was decoded.
  a_mmsi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mmsi_found |-> out_mmsi == 30'd0)
    else $error("mmsi nonzero without mmsi_found");

  // Without an address the captured characters read as zero.
  a_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_address |-> out_talker_first == 8'd0 && out_id_third == 8'd0)
    else $error("address characters without an address");

  // A line with a bad start character reports no checksum and no address.
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_field_count == 5'd0 |-> !out_checksum_present && !out_has_address)
    else $error("flags set on a line with an invalid start");

endmodule

bind nmea_sentence_checker nsc_checker u_nsc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_checksum_present (out_checksum_present),
  .out_checksum_valid   (out_checksum_valid),
  .out_has_address      (out_has_address),
  .out_talker_first     (out_talker_first),
  .out_id_third         (out_id_third),
  .out_field_count      (out_field_count),
  .out_sentence_kind    (out_sentence_kind),
  .out_mmsi_found       (out_mmsi_found),
  .out_mmsi             (out_mmsi)
);

`default_nettype wire

// File: sim/tb_nmea_sentence_checker.sv
// Self-checking testbench for nmea_sentence_checker: one line byte per input beat,
// one summary beat per line. Uses nsc_pkg for the result layout and kind table;
// everything else is generated and predicted here.
`timescale 1ns / 100ps

module tb_nmea_sentence_checker
  import nsc_pkg::*;
();

  localparam int FIELD_CAP   = 20;
  localparam int IDLE_PCT    = 13;      // chance in a hundred that a side idles in a cycle
  localparam int STALL_CYCLES = 300;    // length of the long receiver hold-off
  localparam int RANDOM_BYTES = 900;    // random line bytes to offer
  localparam int QUIET_BYTES  = 300;    // of those, bytes sent with no idling on either side
  localparam int MIN_LINES    = 20;     // fewest random lines with idling, each of which yields one summary
  localparam int DRAIN_CYCLES = 8;      // settle time at the end
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PRINT_CAP    = 40;

  // Field positions inside the body, counted from the address field as field 1.
  localparam logic [4:0] ADDR_FIELD    = 5'd1;
  localparam logic [4:0] FRAG_FIELD    = 5'd3;
  localparam logic [4:0] PAYLOAD_FIELD = 5'd6;
  localparam logic [2:0] ADDR_MIN      = 3'd5;
  localparam logic [2:0] CHAR_SAT      = 3'd7;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] ASCII_CR  = 8'h0D;
  localparam logic [7:0] ASCII_NL  = 8'h0A;

  typedef enum logic [1:0] {LN_START, LN_BODY, LN_STAR, LN_IDLE} line_phase_t;
  typedef enum int {CK_NONE, CK_GOOD, CK_LOWER, CK_BAD, CK_ONE_DIGIT, CK_JUNK} ck_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
  } line_byte_t;

  // Clock, reset and block ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_in = 8'h00;
  logic        in_end_of_line = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_checksum_present;
  logic        out_checksum_valid;
  logic        out_has_address;
  logic [7:0]  out_talker_first;
  logic [7:0]  out_talker_second;
  logic [7:0]  out_id_first;
  logic [7:0]  out_id_second;
  logic [7:0]  out_id_third;
  logic [4:0]  out_field_count;
  logic [3:0]  out_sentence_kind;
  logic        out_mmsi_found;
  logic [29:0] out_mmsi;

  nmea_sentence_checker #(.FIELD_CAP(FIELD_CAP)) DUT (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_byte_in           (in_byte_in),
    .in_end_of_line       (in_end_of_line),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_checksum_present (out_checksum_present),
    .out_checksum_valid   (out_checksum_valid),
    .out_has_address      (out_has_address),
    .out_talker_first     (out_talker_first),
    .out_talker_second    (out_talker_second),
    .out_id_first         (out_id_first),
    .out_id_second        (out_id_second),
    .out_id_third         (out_id_third),
    .out_field_count      (out_field_count),
    .out_sentence_kind    (out_sentence_kind),
    .out_mmsi_found       (out_mmsi_found),
    .out_mmsi             (out_mmsi)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and bookkeeping shared between the processes below.
  line_byte_t  byte_feed[$];          // line bytes waiting for the driver
  logic [7:0]  line_buf[$];           // line under construction
  result_t     pending_summaries[$];  // predicted summaries not yet delivered
  logic        quiet = 1'b0;          // no idling on either side while set
  logic        stall_armed = 1'b0;    // receiver holds off for STALL_CYCLES while set
  int          rx_hold_count = 0;
  int unsigned bytes_queued = 0;
  int unsigned lines_queued = 0;
  int unsigned mismatches = 0;
  int unsigned lines_checked = 0;
  int unsigned kinds_seen = 0;
  int unsigned mmsi_seen = 0;
  int unsigned input_held = 0;
  int unsigned cycle_count = 0;

  // ---------------------------------------------------------------------------
  // Line predictor. The state below mirrors what the block keeps per line; it
  // is cleared whenever a new line starts, so no reset hook is needed.
  // ---------------------------------------------------------------------------
  line_phase_t ln_phase = LN_START;
  logic [7:0]  body_xor;
  logic [2:0]  addr_len;
  logic [15:0] talker_pair;
  logic [23:0] ident_window;
  logic [4:0]  field_idx = 5'd0;
  logic [2:0]  field_chars;
  logic        frag_one;
  logic        payload_full;
  logic [29:0] mmsi_acc;
  logic [1:0]  star_seen;
  logic [4:0]  sum_digit;              // bit 4 says the digits so far are good

  function automatic logic [4:0] hex_nibble(logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return {1'b1, 4'(c - CH_ZERO)};
    if (c >= CH_UA && c <= CH_UF) return {1'b1, 4'(c - CH_UA + 8'd10)};
    if (c >= CH_LA && c <= CH_LF) return {1'b1, 4'(c - CH_LA + 8'd10)};
    return 5'd0;
  endfunction

  // Six-bit AIS armoring: characters above the gap skip eight codes.
  function automatic logic [5:0] armor_value(logic [7:0] c);
    logic [7:0] v;
    v = c - ARMOR_BASE;
    if (v > ARMOR_GAP) v = v - ARMOR_SKIP;
    return v[5:0];
  endfunction

  function automatic void clear_line_state();
    body_xor = 8'h00;
    addr_len = 3'd0;
    talker_pair = 16'h0000;
    ident_window = 24'h000000;
    field_idx = 5'd0;
    field_chars = 3'd0;
    frag_one = 1'b0;
    payload_full = 1'b0;
    mmsi_acc = 30'd0;
    star_seen = 2'd0;
    sum_digit = 5'd0;
  endfunction

  // A body character other than the star: commas open fields until the cap,
  // after which they are ordinary characters of the last field.
  function automatic void take_body_char(logic [7:0] c);
    logic [5:0] six;
    if (c == CH_COMMA && field_idx < FIELD_CAP) begin
      field_idx = field_idx + 5'd1;
      field_chars = 3'd0;
      return;
    end
    if (field_idx == ADDR_FIELD) begin
      if (addr_len == 3'd0) talker_pair[15:8] = c;
      else if (addr_len == 3'd1) talker_pair[7:0] = c;
      if (addr_len < ADDR_MIN) addr_len = addr_len + 3'd1;
      ident_window = {ident_window[15:0], c};
    end else if (field_idx == FRAG_FIELD) begin
      if (field_chars == 3'd0) frag_one = (c == CH_ONE);
    end else if (field_idx == PAYLOAD_FIELD) begin
      // The first payload character is the message type; the next six hold the MMSI.
      six = armor_value(c);
      case (field_chars)
        3'd1: mmsi_acc = {26'd0, six[3:0]};
        3'd2, 3'd3, 3'd4, 3'd5: mmsi_acc = {mmsi_acc[23:0], six};
        3'd6: begin
          mmsi_acc = {mmsi_acc[27:0], six[5:4]};
          payload_full = 1'b1;
        end
        default: ;
      endcase
    end
    if (field_chars < CHAR_SAT) field_chars = field_chars + 3'd1;
  endfunction

  function automatic result_t line_summary();
    result_t r;
    logic    present;
    logic    valid;
    logic    addr;
    r = '0;
    if (field_idx == 5'd0) return r;
    present = (ln_phase == LN_STAR);
    valid = present && star_seen == 2'd2 && sum_digit[4];
    addr = (addr_len >= ADDR_MIN);
    if (valid && addr) begin
      for (int i = 0; i < KIND_COUNT; i++) begin
        if (KIND_TAGS[i] == ident_window && field_idx >= KIND_MIN[i]) r.sentence_kind = 4'(i + 1);
      end
    end
    r.checksum_present = present;
    r.checksum_valid = valid;
    r.has_address = addr;
    if (addr) begin
      r.talker_first = talker_pair[15:8];
      r.talker_second = talker_pair[7:0];
      r.id_first = ident_window[23:16];
      r.id_second = ident_window[15:8];
      r.id_third = ident_window[7:0];
    end
    r.field_count = field_idx;
    r.mmsi_found = (r.sentence_kind == KIND_VDM) && frag_one && payload_full;
    r.mmsi = r.mmsi_found ? mmsi_acc : 30'd0;
    return r;
  endfunction

  task automatic step_line(input logic [7:0] c, input logic eol,
                           output logic emitted, output result_t r);
    logic [4:0] d;
    emitted = 1'b0;
    r = '0;
    case (ln_phase)
      LN_START: begin
        clear_line_state();
        if (c == CH_DOLLAR || c == CH_BANG) begin
          field_idx = ADDR_FIELD;
          ln_phase = LN_BODY;
        end else begin
          ln_phase = LN_IDLE;
        end
      end
      LN_BODY: begin
        if (c == CH_NUL) ln_phase = LN_IDLE;
        else if (c == CH_STAR) ln_phase = LN_STAR;
        else begin
          body_xor = body_xor ^ c;
          take_body_char(c);
        end
      end
      LN_STAR: begin
        // Only the first two characters after the star are looked at.
        d = hex_nibble(c);
        if (star_seen == 2'd0) begin
          sum_digit = d;
          star_seen = 2'd1;
        end else if (star_seen == 2'd1) begin
          sum_digit = (sum_digit[4] && d[4] && {sum_digit[3:0], d[3:0]} == body_xor) ?
                      5'h10 : 5'h00;
          star_seen = 2'd2;
        end
      end
      default: ;
    endcase
    if (eol) begin
      emitted = 1'b1;
      r = line_summary();
      ln_phase = LN_START;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Line construction helpers.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(logic [3:0] n, logic lower);
    if (n < 4'd10) return 8'(CH_ZERO + n);
    return 8'((lower ? CH_LA : CH_UA) + n - 8'd10);
  endfunction

  function automatic logic [7:0] rand_letter();
    return 8'(CH_UA + $urandom_range(25));
  endfunction

  // Printable field content; star and comma would change the line structure.
  function automatic logic [7:0] field_char();
    logic [7:0] c;
    c = 8'($urandom_range(32, 126));
    if (c == CH_STAR || c == CH_COMMA) c = ".";
    return c;
  endfunction

  function automatic logic [7:0] armor_char();
    int v;
    v = $urandom_range(63);
    return (v < 40) ? 8'(ARMOR_BASE + v) : 8'(ARMOR_BASE + ARMOR_SKIP + v);
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endtask

  // Appends the star and checksum digits for the body built so far.
  task automatic add_sum(input ck_mode_t mode);
    logic [7:0] x;
    x = 8'h00;
    if (mode == CK_NONE) return;
    for (int i = 1; i < line_buf.size(); i++) x = x ^ line_buf[i];
    line_buf.push_back(CH_STAR);
    if (mode == CK_BAD) x = x ^ 8'(1 << $urandom_range(7));
    line_buf.push_back(hex_char(x[7:4], mode == CK_LOWER));
    case (mode)
      CK_ONE_DIGIT: ;
      CK_JUNK: begin
        case ($urandom_range(2))
          0: line_buf.push_back(CH_NUL);
          1: line_buf.push_back("g");
          default: line_buf.push_back(" ");
        endcase
      end
      default: line_buf.push_back(hex_char(x[3:0], mode == CK_LOWER));
    endcase
  endtask

  // Moves the finished line into the feed, marking its last byte.
  task automatic push_line();
    for (int i = 0; i < line_buf.size(); i++) begin
      byte_feed.push_back('{line_buf[i], i == line_buf.size() - 1});
    end
    bytes_queued += line_buf.size();
    if (line_buf.size() != 0) lines_queued++;
    line_buf.delete();
  endtask

  task automatic directed(input string s, input ck_mode_t mode);
    add_text(s);
    add_sum(mode);
    push_line();
  endtask

  // A well-formed sentence with random content; most carry a known identifier
  // and about the number of fields that its kind asks for.
  task automatic build_sentence();
    logic [23:0] ident;
    int          fewest;
    int          nf;
    int          plen;
    int          pick;
    ident = 24'h0;
    fewest = 6;
    line_buf.push_back(($urandom_range(3) == 0) ? CH_BANG : CH_DOLLAR);
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(8)) line_buf.push_back(rand_letter());
    end else begin
      line_buf.push_back(rand_letter());
      line_buf.push_back(rand_letter());
      ident = ($urandom_range(7) == 0) ? {rand_letter(), rand_letter(), rand_letter()} :
              KIND_TAGS[$urandom_range(KIND_COUNT - 1)];
      line_buf.push_back(ident[23:16]);
      line_buf.push_back(ident[15:8]);
      line_buf.push_back(ident[7:0]);
    end
    if (ident == "VDM") begin
      add_text($urandom_range(1) ? ",1," : ",2,");
      pick = $urandom_range(7);
      if (pick == 0) add_text("2");
      else if (pick == 1) line_buf.push_back(field_char());
      else add_text("1");
      add_text(",");
      if ($urandom_range(1)) line_buf.push_back(8'(CH_ZERO + $urandom_range(9)));
      add_text($urandom_range(1) ? ",A," : ",B,");
      plen = ($urandom_range(3) == 0) ? $urandom_range(8) : $urandom_range(7, 28);
      repeat (plen) line_buf.push_back(armor_char());
      if ($urandom_range(5) != 0) add_text(",0");
    end else begin
      for (int i = 0; i < KIND_COUNT; i++) begin
        if (KIND_TAGS[i] == ident) fewest = int'(KIND_MIN[i]);
      end
      nf = ($urandom_range(9) == 0) ? $urandom_range(1, 26) :
           fewest + $urandom_range(3) - (($urandom_range(4) == 0) ? 1 : 0);
      for (int f = 2; f <= nf; f++) begin
        line_buf.push_back(CH_COMMA);
        repeat ($urandom_range(6)) line_buf.push_back(field_char());
      end
    end
    pick = $urandom_range(99);
    if (pick < 45) add_sum(CK_GOOD);
    else if (pick < 75) add_sum(CK_LOWER);
    else if (pick < 83) add_sum(CK_BAD);
    else if (pick < 88) add_sum(CK_ONE_DIGIT);
    else if (pick < 93) add_sum(CK_JUNK);
    if ($urandom_range(3) == 0) begin
      line_buf.push_back(ASCII_CR);
      line_buf.push_back(ASCII_NL);
    end
  endtask

  // Mostly good sentences, then damaged ones, noise and very short lines.
  task automatic add_random_line();
    int pick;
    int cut;
    pick = $urandom_range(99);
    if (pick < 72) begin
      build_sentence();
    end else if (pick < 84) begin
      build_sentence();
      case ($urandom_range(2))
        0: begin
          cut = $urandom_range(1, line_buf.size() - 1);
          while (line_buf.size() > cut) void'(line_buf.pop_back());
        end
        1: line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
        default: line_buf[$urandom_range(1, line_buf.size() - 1)] = CH_NUL;
      endcase
    end else if (pick < 93) begin
      line_buf.push_back($urandom_range(1) ? CH_DOLLAR : 8'($urandom_range(255)));
      repeat ($urandom_range(23)) line_buf.push_back(8'($urandom_range(255)));
    end else begin
      line_buf.push_back($urandom_range(1) ? CH_BANG : CH_DOLLAR);
      repeat ($urandom_range(2)) line_buf.push_back(8'($urandom_range(255)));
    end
    push_line();
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (byte_feed.size() != 0 || in_valid || pending_summaries.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the next queued byte. Once a beat is offered it stays on the
  // port until the block takes it.
  // ---------------------------------------------------------------------------
  line_byte_t next_byte;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_byte_in <= 8'h00;
      in_end_of_line <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (byte_feed.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        next_byte = byte_feed.pop_front();
        in_valid <= 1'b1;
        in_byte_in <= next_byte.ch;
        in_end_of_line <= next_byte.eol;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random idling, plus one long hold-off that it times itself so
  // that the block's result register stays full and it pushes back on its input.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold_count <= 0;
    end else if (stall_armed && rx_hold_count < STALL_CYCLES) begin
      out_ready <= 1'b0;
      rx_hold_count <= rx_hold_count + 1;
    end else begin
      if (!stall_armed) rx_hold_count <= 0;
      out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: every accepted input beat runs through the predictor, and every
  // accepted result beat is compared with the oldest predicted summary.
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("ERROR at result %0d, %s: got 0x%0h, expected 0x%0h",
               lines_checked, what, got, want);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  logic    line_done;
  result_t predicted;
  result_t observed;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) input_held++;
      if (in_valid && in_ready) begin
        step_line(in_byte_in, in_end_of_line, line_done, predicted);
        if (line_done) pending_summaries.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_summaries.size() == 0) begin
          report_mismatch("result beat with no line pending", 32'd1, 32'd0);
        end else begin
          predicted = pending_summaries.pop_front();
          observed = '{out_checksum_present, out_checksum_valid, out_has_address,
                       out_talker_first, out_talker_second, out_id_first, out_id_second,
                       out_id_third, out_field_count, out_sentence_kind, out_mmsi_found,
                       out_mmsi};
          check_field("checksum_present", 32'(observed.checksum_present),
                      32'(predicted.checksum_present));
          check_field("checksum_valid", 32'(observed.checksum_valid),
                      32'(predicted.checksum_valid));
          check_field("has_address", 32'(observed.has_address),
                      32'(predicted.has_address));
          check_field("talker_first", 32'(observed.talker_first),
                      32'(predicted.talker_first));
          check_field("talker_second", 32'(observed.talker_second),
                      32'(predicted.talker_second));
          check_field("id_first", 32'(observed.id_first), 32'(predicted.id_first));
          check_field("id_second", 32'(observed.id_second), 32'(predicted.id_second));
          check_field("id_third", 32'(observed.id_third), 32'(predicted.id_third));
          check_field("field_count", 32'(observed.field_count),
                      32'(predicted.field_count));
          check_field("sentence_kind", 32'(observed.sentence_kind),
                      32'(predicted.sentence_kind));
          check_field("mmsi_found", 32'(observed.mmsi_found), 32'(predicted.mmsi_found));
          check_field("mmsi", 32'(observed.mmsi), 32'(predicted.mmsi));
          if (predicted.sentence_kind != KIND_NONE) kinds_seen++;
          if (predicted.mmsi_found) mmsi_seen++;
        end
        lines_checked++;
      end
    end
  end

  // A hang anywhere ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped at the cycle limit with %0d summaries outstanding",
               pending_summaries.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int unsigned random_start;

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed lines: one of each sentence kind, then the corner cases.
    directed("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", CK_GOOD);
    directed("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W", CK_LOWER);
    directed("$GPVTG,054.7,T,034.4,M,005.5,N,010.2,K", CK_GOOD);
    directed("$HEHDT,274.07,T", CK_GOOD);
    directed("$HCHDG,98.3,0.0,E,12.6,W", CK_LOWER);
    directed("$YXMTW,17.75,C", CK_GOOD);
    directed("$SDDBT,7.8,f,2.4,M,1.3,F", CK_GOOD);
    directed("$SDDPT,2.4,0.5", CK_GOOD);
    directed("$WIMWV,214.8,R,0.1,K,A", CK_GOOD);
    directed("$WIMWD,10.1,T,10.1,M,12,N,40,M", CK_GOOD);
    directed("!AIVDM,1,1,,B,177KQJ5000G?tOwK>RA1wUbN0TKH,0", CK_GOOD);
    // Second fragment, then payloads one short of and exactly long enough for an MMSI.
    directed("!AIVDM,2,2,3,B,1@0000000000000,2", CK_GOOD);
    directed("!AIVDM,1,1,,A,13aEOK,0", CK_GOOD);
    directed("!AIVDM,1,1,,A,13aEOKw,0", CK_GOOD);
    // Known identifier with too few fields, then a wrong checksum.
    directed("$GPGGA,1,2,3,4,5", CK_GOOD);
    directed("$GPRMC,1,2,3,4,5,6,7,8,9", CK_BAD);
    // The line ends after one digit, and a non-hex digit follows the star.
    directed("$GPHDT,1,T", CK_ONE_DIGIT);
    directed("$GPHDT,1,T", CK_JUNK);
    // A zero byte cuts the body short; the star after it is never seen.
    add_text("$GPHDT,1,T");
    line_buf.push_back(CH_NUL);
    add_text("*00");
    push_line();
    // Short and long address fields.
    directed("$GP,1,2", CK_GOOD);
    directed("$PGRMEX,1", CK_GOOD);
    // More commas than the field cap allows.
    add_text("$GPGGA");
    repeat (24) add_text(",1");
    add_sum(CK_GOOD);
    push_line();
    // Invalid starts, one-byte lines, an empty body and trailing line ending.
    directed("XGPGGA,1,2,3,4,5,6", CK_GOOD);
    line_buf.push_back(8'hFF);
    add_text("$GPHDT,1*");
    push_line();
    directed("$", CK_NONE);
    directed("!", CK_NONE);
    directed("A", CK_NONE);
    directed("$", CK_GOOD);
    directed("$*", CK_NONE);
    add_text("$GPHDT,1,T");
    add_sum(CK_GOOD);
    line_buf.push_back(ASCII_CR);
    line_buf.push_back(ASCII_NL);
    push_line();

    // The sender pauses here until every summary is back.
    wait_drained();

    // Long receiver hold-off while short lines keep coming, so that the block
    // runs out of room for summaries and stops taking bytes.
    stall_armed = 1'b1;
    repeat (40) directed($urandom_range(1) ? "$" : "!", CK_NONE);
    repeat (4) begin
      build_sentence();
      push_line();
    end
    wait_drained();
    stall_armed = 1'b0;

    // Random lines: first a stretch with both sides always ready, then with idling.
    random_start = bytes_queued;
    quiet = 1'b1;
    while (bytes_queued - random_start < QUIET_BYTES) add_random_line();
    wait_drained();
    quiet = 1'b0;
    lines_queued = 0;
    while (bytes_queued - random_start < RANDOM_BYTES || lines_queued < MIN_LINES) begin
      add_random_line();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_summaries.size() != 0) begin
      report_mismatch("summaries never delivered", pending_summaries.size(), 32'd0);
    end

    $display("Checked %0d line summaries over %0d line bytes; %0d named a kind, %0d an MMSI.",
             lines_checked, bytes_queued, kinds_seen, mmsi_seen);
    $display("Input was held back for %0d cycles; %0d mismatches found.",
             input_held, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
